### rtl/psm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psm_pkg;

   localparam int MAX_ITEMS  = 256;
   localparam int CELL_W     = $clog2(MAX_ITEMS);
   localparam int COUNT_W    = CELL_W + 1;
   localparam int DATA_W     = 32;
   localparam int NEED_W     = DATA_W + 1;
   localparam int OUT_IDX_W  = 8;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_TARGET_SUM = 1'b0;

   typedef struct packed {
      logic                valid;
      logic                last;
      logic                ovf;
      logic                hit;
      logic [CELL_W-1:0]   hit_idx;
      logic [COUNT_W-1:0]  idx;
      logic [NEED_W-1:0]   need;
      logic [DATA_W-1:0]   value;
   } psm_query_type;

endpackage

`default_nettype wire

### rtl/streaming_pair_sum_matcher_unit.sv
// throughput: one transaction per cycle; each search walks the row of 256 cells,
// one cell per cycle, each cell holding one stored element of the current array
// the whole row stalls only when a result reaches the output register while it still holds an untaken one
// reset is synchronous: count, pair latch, valid flags and target_sum clear;
// stored elements stay undefined and are never compared before being written
`timescale 1ns / 1ps
`default_nettype none

module streaming_pair_sum_matcher_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,  // value[31:0]
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // found[0], earlier_index[8:1], later_index[16:9], overflow[17], zero[23:18]
   output logic [psm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [psm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [psm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [psm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import psm_pkg::*;

   logic [DATA_W-1:0]   target_ff;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                adv;
   logic                accept;
   logic                full;
   logic                csr_sel_target;
   psm_query_type       entry_q;
   psm_query_type       chain [0:MAX_ITEMS];
   logic                found;
   logic [OUT_IDX_W-1:0] earlier_index, later_index;
   logic                overflow;

   // configuration
   assign csr_pready     = 1'b1;
   assign csr_sel_target = csr_paddr[2] == CSR_TARGET_SUM;
   assign csr_prdata     = csr_sel_target ? target_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_target) begin
         target_ff <= csr_pwdata;
      end
   end

   // entry: index, capacity check and complement
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;
   assign full       = count_ff == COUNT_W'(MAX_ITEMS);

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_tlast) begin
            count_in = '0;
         end else if (!full) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end

      entry_q.valid   = accept;
      entry_q.last    = req_tlast;
      entry_q.ovf     = full;
      entry_q.hit     = 1'b0;
      entry_q.hit_idx = '0;
      entry_q.idx     = count_ff;
      entry_q.need    = {target_ff[DATA_W-1], target_ff} - {req_tdata[DATA_W-1], req_tdata};
      entry_q.value   = req_tdata;
   end

   assign chain[0] = entry_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // row of search cells
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      psm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .adv         (adv),
         .cell_index  (CELL_W'(i)),
         .cell_q_prev (chain[i]),
         .cell_q_next (chain[i+1])
      );
   end

   psm_latch u_latch (
      .clock        (clock),
      .reset        (reset),
      .tail_q       (chain[MAX_ITEMS]),
      .rsp_ready    (rsp_tready),
      .adv          (adv),
      .rsp_valid    (rsp_tvalid),
      .rsp_found    (found),
      .rsp_earlier  (earlier_index),
      .rsp_later    (later_index),
      .rsp_overflow (overflow),
      .rsp_done     (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W - 2 * OUT_IDX_W - 2)'(0), overflow, later_index,
                       earlier_index, found};

endmodule

`default_nettype wire

### rtl/psm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module psm_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic [psm_pkg::CELL_W-1:0]   cell_index,
   input  psm_pkg::psm_query_type       cell_q_prev,
   output psm_pkg::psm_query_type       cell_q_next
);
   import psm_pkg::*;

   logic [DATA_W-1:0] stored_ff;
   psm_query_type     q_ff;
   psm_query_type     q_in;
   logic              own_slot;
   logic              older_slot;
   logic              match;

   always_comb begin
      own_slot   = cell_q_prev.idx == {1'b0, cell_index};
      older_slot = {1'b0, cell_index} < cell_q_prev.idx;
      match      = cell_q_prev.valid && !cell_q_prev.ovf && older_slot &&
                   ({stored_ff[DATA_W-1], stored_ff} == cell_q_prev.need);
      q_in = cell_q_prev;
      if (match) begin
         q_in.hit     = 1'b1;
         q_in.hit_idx = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else if (adv) begin
         q_ff <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && cell_q_prev.valid && !cell_q_prev.ovf && own_slot) begin
         stored_ff <= cell_q_prev.value;
      end
   end

   assign cell_q_next = q_ff;

endmodule

`default_nettype wire

### rtl/psm_latch.sv
`timescale 1ns / 1ps
`default_nettype none

module psm_latch (
   input  logic                            clock,
   input  logic                            reset,
   input  psm_pkg::psm_query_type          tail_q,
   input  logic                            rsp_ready,
   output logic                            adv,
   output logic                            rsp_valid,
   output logic                            rsp_found,
   output logic [psm_pkg::OUT_IDX_W-1:0]   rsp_earlier,
   output logic [psm_pkg::OUT_IDX_W-1:0]   rsp_later,
   output logic                            rsp_overflow,
   output logic                            rsp_done
);
   import psm_pkg::*;

   logic                 found_ff, found_in;
   logic [CELL_W-1:0]    earlier_ff, earlier_in;
   logic [CELL_W-1:0]    later_ff, later_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff;
   logic [OUT_IDX_W-1:0] rsp_earlier_ff, rsp_later_ff;
   logic                 rsp_overflow_ff, rsp_done_ff;
   logic                 load;
   logic                 found_now;
   logic [CELL_W-1:0]    earlier_now, later_now;

   always_comb begin
      adv  = !(tail_q.valid && rsp_valid_ff && !rsp_ready);
      load = tail_q.valid && adv;

      found_now   = found_ff || tail_q.hit;
      earlier_now = found_ff ? earlier_ff : tail_q.hit_idx;
      later_now   = found_ff ? later_ff : tail_q.idx[CELL_W-1:0];

      found_in   = found_ff;
      earlier_in = earlier_ff;
      later_in   = later_ff;
      if (load) begin
         if (tail_q.last) begin
            found_in   = 1'b0;
            earlier_in = '0;
            later_in   = '0;
         end else begin
            found_in   = found_now;
            earlier_in = earlier_now;
            later_in   = later_now;
         end
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         earlier_ff   <= '0;
         later_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         found_ff     <= found_in;
         earlier_ff   <= earlier_in;
         later_ff     <= later_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_found_ff    <= found_now;
         rsp_earlier_ff  <= found_now ? OUT_IDX_W'(earlier_now) : '0;
         rsp_later_ff    <= found_now ? OUT_IDX_W'(later_now) : '0;
         rsp_overflow_ff <= tail_q.ovf;
         rsp_done_ff     <= tail_q.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_earlier  = rsp_earlier_ff;
   assign rsp_later    = rsp_later_ff;
   assign rsp_overflow = rsp_overflow_ff;
   assign rsp_done     = rsp_done_ff;

endmodule

`default_nettype wire

### rtl/psm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module psm_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [psm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              rsp_tlast
);
   import psm_pkg::*;

   // held result must not change
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // no pair means both indices read zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[2*OUT_IDX_W:1] == '0)
      else $error("indices set without a pair");

   // the later element of a pair comes after the earlier one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |->
         rsp_tdata[2*OUT_IDX_W:OUT_IDX_W+1] > rsp_tdata[OUT_IDX_W:1])
      else $error("pair indices out of order");

   // nothing is offered straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind streaming_pair_sum_matcher_unit psm_checker u_psm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
